// ===== rtl/terrain_path_energy_accumulator_defines.svh =====
// Assertion macros for the files that check their own logic.
`ifndef TERRAIN_PATH_ENERGY_ACCUMULATOR_DEFINES_SVH
`define TERRAIN_PATH_ENERGY_ACCUMULATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TPEA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tpea assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TPEA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tpea assertion failed");

`endif

// ===== rtl/tpea_pkg.sv =====
package tpea_pkg;

  localparam int COORD_BITS = 12;
  localparam int ELEV_BITS  = 8;
  localparam int FRAC_BITS  = 16;
  localparam int RC_FRAC    = 16;

  localparam int CFG_W   = 32;
  localparam int RC_W    = 16;
  localparam int RUN_W   = CFG_W + 1;
  localparam int RUN2_W  = 2 * RUN_W;
  localparam int RISE_W  = ELEV_BITS + CFG_W;
  localparam int SQ_W    = 2 * RISE_W + 1;
  localparam int RAD_W   = SQ_W + 1;
  localparam int SEG_W   = RAD_W / 2;
  localparam int GM_W    = 2 * CFG_W - FRAC_BITS;
  localparam int G_W     = GM_W + RISE_W;
  localparam int R_W     = GM_W + SEG_W;
  localparam int MAG_W   = R_W + 1;
  localparam int DM_W    = 57;
  localparam int LEN_W   = 48;
  localparam int EN_W    = 56;
  localparam int NEED_W  = 55;
  localparam int ACC_W   = EN_W + 2;

  localparam int MUL_W   = 48;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int MUL_CNT_W = $clog2(MUL_W);
  localparam int SQ_CNT_W  = $clog2(SEG_W);
  localparam int REM_W   = SEG_W + 2;

  localparam logic [CFG_W-1:0] ROOT2_FRAC = 32'd1779033704;
  localparam logic [DM_W-1:0]  DELTA_CAP  = {1'b1, {(DM_W-1){1'b0}}};

  localparam logic [CFG_W-1:0] HS_RESET   = 32'd65536;
  localparam logic [CFG_W-1:0] VS_RESET   = 32'd65536;
  localparam logic [CFG_W-1:0] GRAV_RESET = 32'd642908;
  localparam logic [CFG_W-1:0] MASS_RESET = 32'd65536;
  localparam logic [RC_W-1:0]  RC_RESET   = 16'd0;

  typedef enum logic [2:0] {
    REG_HSCALE = 3'd0,
    REG_VSCALE = 3'd1,
    REG_GRAV   = 3'd2,
    REG_MASS   = 3'd3,
    REG_RCOEFF = 3'd4
  } tpea_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_GM, ST_RF, ST_DIAG, ST_RUN2, ST_RISE, ST_RISE2, ST_SQRT,
    ST_G, ST_R, ST_MAG, ST_CAP, ST_ACC, ST_DONE
  } tpea_state_t;

endpackage

// ===== rtl/tpea_if.sv =====
interface tpea_in_if import tpea_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] x_coord;
  logic [COORD_BITS-1:0] y_coord;
  logic [ELEV_BITS-1:0]  elevation;
  logic                  path_start;

  modport source (output valid, x_coord, y_coord, elevation, path_start, input ready);
  modport sink   (input valid, x_coord, y_coord, elevation, path_start, output ready);
endinterface

interface tpea_out_if import tpea_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [LEN_W-1:0]         path_length;
  logic signed [EN_W-1:0]   net_energy;
  logic [NEED_W-1:0]        needed_energy;
  logic                     saturated;

  modport source (output valid, path_length, net_energy, needed_energy, saturated,
                  input ready);
  modport sink   (input valid, path_length, net_energy, needed_energy, saturated,
                  output ready);
endinterface

// ===== rtl/terrain_path_energy_accumulator.sv =====
// A step between two points is registered as a result after eight products on one shared
// bit-serial shift-add multiplier, a digit-by-digit square root and the steps MAG, CAP and ACC
// that form the totals; the result then waits in DONE until the output is free. A path start or
// a first point goes from acceptance straight to DONE.
// Throughput: one point at a time; the next is accepted once the result is registered.
// Reset (synchronous, active low) restores the register defaults and clears all totals.
`include "terrain_path_energy_accumulator_defines.svh"

module terrain_path_energy_accumulator import tpea_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  tpea_in_if.sink           in_ch,
  tpea_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  tpea_state_t state_r, state_nxt;
  logic        issued_r, issued_nxt;

  logic [CFG_W-1:0] hs_r, vs_r, grav_r, mass_r;
  logic [RC_W-1:0]  rc_r;

  logic [COORD_BITS-1:0] prev_x_r, prev_y_r;
  logic [ELEV_BITS-1:0]  prev_e_r, d_r;
  logic                  have_prev_r, straight_r, down_r;

  logic [GM_W-1:0]   gm_r, rf_r;
  logic [RUN_W-1:0]  run_r;
  logic [RUN2_W-1:0] run2_r;
  logic [RISE_W-1:0] rise_r;
  logic [SQ_W-1:0]   sumsq_r;
  logic [SEG_W-1:0]  seg_r;
  logic [G_W-1:0]    g_r;
  logic [R_W-1:0]    r_r;
  logic [MAG_W-1:0]  mag_r;
  logic              neg_r;
  logic [DM_W-1:0]   dm_r;

  logic [LEN_W-1:0]       len_r;
  logic signed [EN_W-1:0] en_r;
  logic [NEED_W-1:0]      need_r;
  logic                   sat_r;

  logic                   out_valid_r;
  logic [LEN_W-1:0]       out_len_r;
  logic signed [EN_W-1:0] out_en_r;
  logic [NEED_W-1:0]      out_need_r;
  logic                   out_sat_r;

  logic              in_acc, out_free, is_mul;
  logic              mul_start, mul_busy, mul_done;
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] mul_p;
  logic              sqrt_start, sqrt_busy, sqrt_done;
  logic [SEG_W-1:0]  sqrt_root;

  logic [MAG_W-1:0]        mag_sum, mag_rg, mag_gr;
  logic                    r_ge_g;
  logic [MAG_W-FRAC_BITS-1:0] m16;
  logic [LEN_W:0]          nl;
  logic signed [ACC_W-1:0] en_ext, dm_ext, ne;
  logic [ACC_W-1:0]        nn;
  logic                    len_sat, en_hi, en_lo, need_sat;

  localparam logic signed [ACC_W-1:0] EN_MAX_X = ACC_W'((64'd1 << (EN_W - 1)) - 64'd1);
  localparam logic signed [ACC_W-1:0] EN_MIN_X = -EN_MAX_X - ACC_W'(1);

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  tpea_smul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .done  (mul_done),
    .p     (mul_p)
  );

  tpea_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .rad   ({1'b0, sumsq_r}),
    .busy  (sqrt_busy),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    is_mul = 1'b1;
    case (state_r)
      ST_GM: begin
        mul_a = MUL_W'(grav_r);
        mul_b = MUL_W'(mass_r);
      end
      ST_RF: begin
        mul_a = MUL_W'(gm_r);
        mul_b = MUL_W'(rc_r);
      end
      ST_DIAG: begin
        mul_a = MUL_W'(hs_r);
        mul_b = MUL_W'(ROOT2_FRAC);
      end
      ST_RUN2: begin
        mul_a = MUL_W'(run_r);
        mul_b = MUL_W'(run_r);
      end
      ST_RISE: begin
        mul_a = MUL_W'(vs_r);
        mul_b = MUL_W'(d_r);
      end
      ST_RISE2: begin
        mul_a = MUL_W'(rise_r);
        mul_b = MUL_W'(rise_r);
      end
      ST_G: begin
        mul_a = MUL_W'(gm_r);
        mul_b = MUL_W'(rise_r);
      end
      ST_R: begin
        mul_a = MUL_W'(rf_r);
        mul_b = MUL_W'(seg_r);
      end
      default: is_mul = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    issued_nxt  = issued_r;
    mul_start   = 1'b0;
    sqrt_start  = 1'b0;
    in_ch.ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          state_nxt = (in_ch.path_start || !have_prev_r) ? ST_DONE : ST_GM;
        end
      end
      ST_GM, ST_RF, ST_DIAG, ST_RUN2, ST_RISE, ST_RISE2, ST_G, ST_R: begin
        if (!issued_r) begin
          mul_start  = 1'b1;
          issued_nxt = 1'b1;
        end else if (mul_done) begin
          issued_nxt = 1'b0;
          case (state_r)
            ST_GM:    state_nxt = ST_RF;
            ST_RF:    state_nxt = ST_DIAG;
            ST_DIAG:  state_nxt = ST_RUN2;
            ST_RUN2:  state_nxt = ST_RISE;
            ST_RISE:  state_nxt = ST_RISE2;
            ST_RISE2: state_nxt = ST_SQRT;
            ST_G:     state_nxt = ST_R;
            default:  state_nxt = ST_MAG;
          endcase
        end
      end
      ST_SQRT: begin
        if (!issued_r) begin
          sqrt_start = 1'b1;
          issued_nxt = 1'b1;
        end else if (sqrt_done) begin
          issued_nxt = 1'b0;
          state_nxt  = ST_G;
        end
      end
      ST_MAG:  state_nxt = ST_CAP;
      ST_CAP:  state_nxt = ST_ACC;
      ST_ACC:  state_nxt = ST_DONE;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Energy magnitude: grade and rolling terms add going down, otherwise they oppose.
  always_comb begin
    mag_sum  = MAG_W'(g_r) + MAG_W'(r_r);
    mag_rg   = MAG_W'(r_r) - MAG_W'(g_r);
    mag_gr   = MAG_W'(g_r) - MAG_W'(r_r);
    r_ge_g   = (MAG_W'(r_r) >= MAG_W'(g_r));
    m16      = mag_r[MAG_W-1:FRAC_BITS];
    nl       = {1'b0, len_r} + (LEN_W+1)'(seg_r);
    en_ext   = ACC_W'(en_r);
    dm_ext   = $signed(ACC_W'(dm_r));
    ne       = neg_r ? (en_ext - dm_ext) : (en_ext + dm_ext);
    nn       = ACC_W'(need_r) + ACC_W'(dm_r);
    len_sat  = nl[LEN_W];
    en_hi    = (ne > EN_MAX_X);
    en_lo    = (ne < EN_MIN_X);
    need_sat = !neg_r && (nn > ACC_W'(EN_MAX_X));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      issued_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      issued_r <= issued_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hs_r   <= HS_RESET;
      vs_r   <= VS_RESET;
      grav_r <= GRAV_RESET;
      mass_r <= MASS_RESET;
      rc_r   <= RC_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HSCALE: hs_r   <= cfg_data;
        REG_VSCALE: vs_r   <= cfg_data;
        REG_GRAV:   grav_r <= cfg_data;
        REG_MASS:   mass_r <= cfg_data;
        REG_RCOEFF: rc_r   <= cfg_data[RC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      prev_e_r    <= '0;
      have_prev_r <= 1'b0;
      len_r       <= '0;
      en_r        <= '0;
      need_r      <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_DONE && out_free) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            // The step is described by these three; the new point becomes the previous one.
            straight_r  <= (in_ch.x_coord == prev_x_r) || (in_ch.y_coord == prev_y_r);
            down_r      <= (prev_e_r >= in_ch.elevation);
            d_r         <= (in_ch.elevation >= prev_e_r) ? (in_ch.elevation - prev_e_r)
                                                          : (prev_e_r - in_ch.elevation);
            prev_x_r    <= in_ch.x_coord;
            prev_y_r    <= in_ch.y_coord;
            prev_e_r    <= in_ch.elevation;
            have_prev_r <= 1'b1;
            if (in_ch.path_start) begin
              len_r  <= '0;
              en_r   <= '0;
              need_r <= '0;
              sat_r  <= 1'b0;
            end
          end
        end
        ST_GM:   if (mul_done) gm_r <= mul_p[FRAC_BITS +: GM_W];
        ST_RF:   if (mul_done) rf_r <= mul_p[RC_FRAC +: GM_W];
        ST_DIAG: begin
          // The fraction of root two in Q0.32; the product is rounded to nearest before adding the whole part.
          if (mul_done) begin
            run_r <= straight_r ? RUN_W'(hs_r)
                   : RUN_W'(hs_r) + RUN_W'(mul_p[2*CFG_W-1:CFG_W]) + RUN_W'(mul_p[CFG_W-1]);
          end
        end
        ST_RUN2:  if (mul_done) run2_r <= mul_p[RUN2_W-1:0];
        ST_RISE:  if (mul_done) rise_r <= mul_p[RISE_W-1:0];
        ST_RISE2: if (mul_done) sumsq_r <= SQ_W'(run2_r) + SQ_W'(mul_p[2*RISE_W-1:0]);
        ST_SQRT:  if (sqrt_done) seg_r <= sqrt_root;
        ST_G:     if (mul_done) g_r <= mul_p[G_W-1:0];
        ST_R:     if (mul_done) r_r <= mul_p[R_W-1:0];
        ST_MAG: begin
          if (down_r) begin
            mag_r <= mag_sum;
            neg_r <= 1'b0;
          end else if (r_ge_g) begin
            mag_r <= mag_rg;
            neg_r <= 1'b0;
          end else begin
            mag_r <= mag_gr;
            neg_r <= 1'b1;
          end
        end
        ST_CAP: dm_r <= (m16 > (MAG_W-FRAC_BITS)'(DELTA_CAP)) ? DELTA_CAP : m16[DM_W-1:0];
        ST_ACC: begin
          len_r <= len_sat ? '1 : nl[LEN_W-1:0];
          if (en_hi) begin
            en_r <= EN_W'(EN_MAX_X);
          end else if (en_lo) begin
            en_r <= EN_W'(EN_MIN_X);
          end else begin
            en_r <= ne[EN_W-1:0];
          end
          if (!neg_r) begin
            need_r <= need_sat ? '1 : nn[NEED_W-1:0];
          end
          sat_r <= sat_r | len_sat | en_hi | en_lo | need_sat;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_len_r  <= len_r;
      out_en_r   <= en_r;
      out_need_r <= need_r;
      out_sat_r  <= sat_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.path_length   = out_len_r;
  assign out_ch.net_energy    = out_en_r;
  assign out_ch.needed_energy = out_need_r;
  assign out_ch.saturated     = out_sat_r;

  `TPEA_ASSERT_NOW(a_mul_done_in_mul_state, clk, rst_n, mul_done, is_mul && issued_r)
  `TPEA_ASSERT_NOW(a_sqrt_done_in_sqrt, clk, rst_n, sqrt_done, state_r == ST_SQRT)
  `TPEA_ASSERT_NOW(a_units_idle_on_request, clk, rst_n, in_acc, !mul_busy && !sqrt_busy)
  `TPEA_ASSERT_NEXT(a_start_clears_totals, clk, rst_n, in_acc && in_ch.path_start,
                    len_r == '0 && en_r == '0 && need_r == '0 && !sat_r)

endmodule

// ===== rtl/tpea_smul.sv =====
module tpea_smul import tpea_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [MUL_W-1:0]  a,
  input  logic [MUL_W-1:0]  b,
  output logic              busy,
  output logic              done,
  output logic [PROD_W-1:0] p
);

  logic [MUL_W-1:0]     a_r;
  logic [MUL_W-1:0]     hi_r;
  logic [MUL_W-1:0]     lo_r;
  logic [MUL_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [MUL_W:0]       sum;

  // One bit of the multiplier a cycle: add the multiplicand, then shift right.
  assign sum = {1'b0, hi_r} + (lo_r[0] ? {1'b0, a_r} : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == MUL_CNT_W'(MUL_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      a_r  <= a;
      hi_r <= '0;
      lo_r <= b;
    end else if (busy_r) begin
      hi_r <= sum[MUL_W:1];
      lo_r <= {sum[0], lo_r[MUL_W-1:1]};
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign p    = {hi_r, lo_r};

endmodule

// ===== rtl/tpea_sqrt.sv =====
module tpea_sqrt import tpea_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [RAD_W-1:0] rad,
  output logic             busy,
  output logic             done,
  output logic [SEG_W-1:0] root
);

  logic [RAD_W-1:0]    rad_r;
  logic [REM_W:0]      rem_r;
  logic [SEG_W-1:0]    root_r;
  logic [SQ_CNT_W-1:0] cnt_r;
  logic                busy_r;
  logic                done_r;
  logic [REM_W+2:0]    rem_sh;
  logic [REM_W+2:0]    trial;
  logic [REM_W+2:0]    diff;
  logic                take;

  // Two radicand bits a step, one root bit out, as in long-hand square root.
  always_comb begin
    rem_sh = {rem_r, rad_r[RAD_W-1 -: 2]};
    trial  = {2'b00, root_r, 2'b01};
    diff   = rem_sh - trial;
    take   = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == SQ_CNT_W'(SEG_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      rad_r  <= rad;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
      rem_r  <= take ? diff[REM_W:0] : rem_sh[REM_W:0];
      root_r <= {root_r[SEG_W-2:0], take};
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign root = root_r;

endmodule
